// ===== design/hse_pkg.sv =====
// shared types and constants of the heap sort engine
package hse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_BUILD,
    ST_SIFT_GET,
    ST_SIFT_LC,
    ST_SIFT_CL,
    ST_SIFT_CR,
    ST_SIFT_SWAP,
    ST_EXTRACT,
    ST_X_GET,
    ST_X_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } hse_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_BUILD_NEXT,
    CMD_SIFT_GET,
    CMD_RD_LC,
    CMD_CMP_L,
    CMD_CMP_R,
    CMD_MOVE,
    CMD_PUT,
    CMD_START_X,
    CMD_RD_ROOT,
    CMD_HOLD_ROOT,
    CMD_SWAP_END,
    CMD_EMIT_START,
    CMD_RD_IDX,
    CMD_LOAD_OUT
  } hse_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_gt1;
    logic lc_in;
    logic rc_in;
    logic big_is_node;
    logic out_last;
  } hse_status_t;

  typedef struct packed {
    hse_cmd_t cmd;
    logic     next_idx;
    logic     clear;
  } hse_ctrl_t;

endpackage

// ===== design/hse_ram.sv =====
// generic single write port ram with registered read
module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hse_dp.sv =====
// datapath: element store, heap indexes, sift registers and output word
module hse_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hse_pkg::hse_ctrl_t              ctrl,
  input  logic signed [hse_pkg::DATA_W-1:0] in_value,
  input  logic                            in_is_last,
  output hse_pkg::hse_status_t            status,
  output logic signed [hse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                            out_last_out
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = IW + 2;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] node_r, node_nxt;
  logic [IW-1:0] big_idx_r, big_idx_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic signed [hse_pkg::DATA_W-1:0] cur_val_r, cur_val_nxt;
  logic signed [hse_pkg::DATA_W-1:0] big_val_r, big_val_nxt;
  logic signed [hse_pkg::DATA_W-1:0] out_val_r, out_val_nxt;
  logic out_last_r, out_last_nxt;

  logic                      we;
  logic [IW-1:0]             waddr;
  logic [hse_pkg::DATA_W-1:0] wdata;
  logic [IW-1:0]             raddr;
  logic [hse_pkg::DATA_W-1:0] rdata;
  logic signed [hse_pkg::DATA_W-1:0] rval;

  logic [LW-1:0] lc_w, rc_w, len_w;
  logic [CW-1:0] km1, cnt_new;
  logic          cnt_full;

  hse_ram #(.WIDTH(hse_pkg::DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rval     = $signed(rdata);
  assign lc_w     = {1'b0, node_r, 1'b1};
  assign rc_w     = lc_w + LW'(1);
  assign len_w    = LW'(len_r);
  assign km1      = k_r - CW'(1);
  assign cnt_full = (cnt_r == CW'(DEPTH));
  assign cnt_new  = cnt_full ? cnt_r : cnt_r + CW'(1);

  assign status.k_zero      = (k_r == '0);
  assign status.k_gt1       = (k_r > CW'(1));
  assign status.lc_in       = (lc_w < len_w);
  assign status.rc_in       = (rc_w < len_w);
  assign status.big_is_node = (big_idx_r == node_r);
  assign status.out_last    = out_last_r;

  assign out_sorted_value = out_val_r;
  assign out_last_out     = out_last_r;

  always_comb begin
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    k_nxt        = k_r;
    node_nxt     = node_r;
    big_idx_nxt  = big_idx_r;
    idx_nxt      = idx_r;
    cur_val_nxt  = cur_val_r;
    big_val_nxt  = big_val_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    we           = 1'b0;
    waddr        = '0;
    wdata        = cur_val_r;
    raddr        = '0;
    case (ctrl.cmd)
      hse_pkg::CMD_STORE: begin
        we      = !cnt_full;
        waddr   = cnt_r[IW-1:0];
        wdata   = in_value;
        cnt_nxt = cnt_new;
        if (in_is_last) begin
          len_nxt = cnt_new;
          k_nxt   = cnt_new >> 1;
        end
      end
      hse_pkg::CMD_BUILD_NEXT: begin
        raddr    = km1[IW-1:0];
        node_nxt = km1[IW-1:0];
        k_nxt    = km1;
      end
      hse_pkg::CMD_SIFT_GET: begin
        cur_val_nxt = rval;
        big_val_nxt = rval;
        big_idx_nxt = node_r;
      end
      hse_pkg::CMD_RD_LC: begin
        raddr = lc_w[IW-1:0];
      end
      hse_pkg::CMD_CMP_L: begin
        raddr = rc_w[IW-1:0];
        if (rval > big_val_r) begin
          big_val_nxt = rval;
          big_idx_nxt = lc_w[IW-1:0];
        end
      end
      hse_pkg::CMD_CMP_R: begin
        if (rval > big_val_r) begin
          big_val_nxt = rval;
          big_idx_nxt = rc_w[IW-1:0];
        end
      end
      hse_pkg::CMD_MOVE: begin
        we          = 1'b1;
        waddr       = node_r;
        wdata       = big_val_r;
        node_nxt    = big_idx_r;
        big_val_nxt = cur_val_r;
      end
      hse_pkg::CMD_PUT: begin
        we    = 1'b1;
        waddr = node_r;
        wdata = cur_val_r;
      end
      hse_pkg::CMD_START_X: begin
        k_nxt = len_r;
      end
      hse_pkg::CMD_RD_ROOT: begin
        raddr = '0;
      end
      hse_pkg::CMD_HOLD_ROOT: begin
        big_val_nxt = rval;
        raddr       = km1[IW-1:0];
      end
      hse_pkg::CMD_SWAP_END: begin
        we          = 1'b1;
        waddr       = km1[IW-1:0];
        wdata       = big_val_r;
        cur_val_nxt = rval;
        big_val_nxt = rval;
        node_nxt    = '0;
        big_idx_nxt = '0;
        k_nxt       = km1;
        len_nxt     = km1;
      end
      hse_pkg::CMD_EMIT_START: begin
        idx_nxt = '0;
      end
      hse_pkg::CMD_RD_IDX: begin
        raddr = idx_r;
      end
      hse_pkg::CMD_LOAD_OUT: begin
        out_val_nxt  = rval;
        out_last_nxt = ((CW'(idx_r) + CW'(1)) == cnt_r);
      end
      default: begin
      end
    endcase
    if (ctrl.next_idx) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      len_r      <= '0;
      k_r        <= '0;
      node_r     <= '0;
      big_idx_r  <= '0;
      idx_r      <= '0;
      out_last_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      k_r        <= k_nxt;
      node_r     <= node_nxt;
      big_idx_r  <= big_idx_nxt;
      idx_r      <= idx_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_val_r <= cur_val_nxt;
    big_val_r <= big_val_nxt;
    out_val_r <= out_val_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_put_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.cmd == hse_pkg::CMD_PUT) |-> (CW'(node_r) < len_r))
    else $error("sift writes outside heap");

  a_emit_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.cmd == hse_pkg::CMD_LOAD_OUT) |-> (CW'(idx_r) < cnt_r))
    else $error("emit index past set");

endmodule

// ===== design/hse_ctrl.sv =====
// controller: collect, heap build, extract and emit sequencing
module hse_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_is_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hse_pkg::hse_status_t status,
  output hse_pkg::hse_ctrl_t   ctrl
);

  hse_pkg::hse_state_t state_r, state_nxt;
  hse_pkg::hse_state_t ret_state;
  logic ret_build_r, ret_build_nxt;

  assign ret_state = ret_build_r ? hse_pkg::ST_BUILD : hse_pkg::ST_EXTRACT;

  always_comb begin
    state_nxt     = state_r;
    ret_build_nxt = ret_build_r;
    case (state_r)
      hse_pkg::ST_COLLECT: begin
        if (in_valid && in_is_last) begin
          state_nxt     = hse_pkg::ST_BUILD;
          ret_build_nxt = 1'b1;
        end
      end
      hse_pkg::ST_BUILD: begin
        if (status.k_zero) begin
          state_nxt     = hse_pkg::ST_EXTRACT;
          ret_build_nxt = 1'b0;
        end else begin
          state_nxt = hse_pkg::ST_SIFT_GET;
        end
      end
      hse_pkg::ST_SIFT_GET:  state_nxt = hse_pkg::ST_SIFT_LC;
      hse_pkg::ST_SIFT_LC: begin
        state_nxt = status.lc_in ? hse_pkg::ST_SIFT_CL : ret_state;
      end
      hse_pkg::ST_SIFT_CL: begin
        state_nxt = status.rc_in ? hse_pkg::ST_SIFT_CR : hse_pkg::ST_SIFT_SWAP;
      end
      hse_pkg::ST_SIFT_CR:   state_nxt = hse_pkg::ST_SIFT_SWAP;
      hse_pkg::ST_SIFT_SWAP: begin
        state_nxt = status.big_is_node ? ret_state : hse_pkg::ST_SIFT_LC;
      end
      hse_pkg::ST_EXTRACT: begin
        state_nxt = status.k_gt1 ? hse_pkg::ST_X_GET : hse_pkg::ST_EMIT_RD;
      end
      hse_pkg::ST_X_GET:     state_nxt = hse_pkg::ST_X_WR;
      hse_pkg::ST_X_WR:      state_nxt = hse_pkg::ST_SIFT_LC;
      hse_pkg::ST_EMIT_RD:   state_nxt = hse_pkg::ST_EMIT_LD;
      hse_pkg::ST_EMIT_LD:   state_nxt = hse_pkg::ST_EMIT_WAIT;
      hse_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          state_nxt = status.out_last ? hse_pkg::ST_COLLECT : hse_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = hse_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctrl.cmd      = hse_pkg::CMD_NONE;
    ctrl.next_idx = 1'b0;
    ctrl.clear    = 1'b0;
    case (state_r)
      hse_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.cmd = hse_pkg::CMD_STORE;
        end
      end
      hse_pkg::ST_BUILD: begin
        ctrl.cmd = status.k_zero ? hse_pkg::CMD_START_X : hse_pkg::CMD_BUILD_NEXT;
      end
      hse_pkg::ST_SIFT_GET: ctrl.cmd = hse_pkg::CMD_SIFT_GET;
      hse_pkg::ST_SIFT_LC: begin
        ctrl.cmd = status.lc_in ? hse_pkg::CMD_RD_LC : hse_pkg::CMD_PUT;
      end
      hse_pkg::ST_SIFT_CL: ctrl.cmd = hse_pkg::CMD_CMP_L;
      hse_pkg::ST_SIFT_CR: ctrl.cmd = hse_pkg::CMD_CMP_R;
      hse_pkg::ST_SIFT_SWAP: begin
        ctrl.cmd = status.big_is_node ? hse_pkg::CMD_PUT : hse_pkg::CMD_MOVE;
      end
      hse_pkg::ST_EXTRACT: begin
        ctrl.cmd = status.k_gt1 ? hse_pkg::CMD_RD_ROOT : hse_pkg::CMD_EMIT_START;
      end
      hse_pkg::ST_X_GET:   ctrl.cmd = hse_pkg::CMD_HOLD_ROOT;
      hse_pkg::ST_X_WR:    ctrl.cmd = hse_pkg::CMD_SWAP_END;
      hse_pkg::ST_EMIT_RD: ctrl.cmd = hse_pkg::CMD_RD_IDX;
      hse_pkg::ST_EMIT_LD: ctrl.cmd = hse_pkg::CMD_LOAD_OUT;
      hse_pkg::ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctrl.next_idx = !status.out_last;
          ctrl.clear    = status.out_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hse_pkg::ST_COLLECT;
      ret_build_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_build_r <= ret_build_nxt;
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !status.out_last) |=> (state_r == hse_pkg::ST_EMIT_RD))
    else $error("emit did not advance");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && status.out_last) |=> in_ready)
    else $error("set end did not reopen input");

endmodule

// ===== design/heap_sort_engine_top.sv =====
// heap sort engine top level: signed 32-bit set sorter
//
// input words (in_value, in_is_last) are taken one per cycle while the block
// is collecting; words beyond DEPTH are dropped. the word with in_is_last set
// closes the set and starts an in-place heapsort in one single-port-read ram.
// heap build and each root extraction sift through the ram level by level
// (child reads, compare, move); each extraction first swaps the root with
// the last heap entry. the single ram read port serialises the child reads.
// the sorted words then leave in ascending order, one at a time, the final
// one with out_last_out. input is closed (in_ready low) from the closing word
// until the last sorted word is taken. a stalled receiver simply holds the
// output word; nothing is lost. reset empties the set and returns to
// collecting; the ram needs no clearing since values read from unwritten
// entries are never used.
module heap_sort_engine_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_is_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_last_out
);

  hse_pkg::hse_ctrl_t   ctrl;
  hse_pkg::hse_status_t status;

  hse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .ctrl       (ctrl)
  );

  hse_dp #(.DEPTH(DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .status           (status),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

endmodule
